// ----- rtl/core/turtle_pen_plotter_defines.svh -----
// Assertion macros shared by the turtle plotter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TURTLE_PEN_PLOTTER_DEFINES_SVH
`define TURTLE_PEN_PLOTTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpp assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpp assertion failed: next-cycle implication");

`endif

// ----- rtl/core/tpp_pkg.sv -----
// Package for the turtle plotter: grid size, command and status codes,
// and the command and response word types. Depends on nothing.
package tpp_pkg;

    localparam int GRID_SIZE = 64;
    localparam int AW        = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int CNT_W     = $clog2(GRID_SIZE + 1);

    typedef enum logic [2:0] {
        REQ_PEN_UP    = 3'd0,
        REQ_PEN_DOWN  = 3'd1,
        REQ_TURN_R    = 3'd2,
        REQ_TURN_L    = 3'd3,
        REQ_MOVE      = 3'd4,
        REQ_DUMP      = 3'd5,
        REQ_END       = 3'd6,
        REQ_INVALID   = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOB     = 2'd1,
        ST_INVALID = 2'd2,
        ST_HALTED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_DOWN  = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_UP    = 2'd3
    } heading_t;

    typedef struct packed {
        req_t       req_type;
        logic [5:0] distance;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  row_index;
        logic [63:0] row_bits;
        logic        last;
        logic [5:0]  pos_row;
        logic [5:0]  pos_col;
        heading_t    heading;
        logic        pen_down;
    } rsp_t;

endpackage

// ----- rtl/core/turtle_pen_plotter.sv -----
// Top level of the turtle plotter: command sequencer, grid memory and
// the shared step adder. Depends on tpp_pkg and turtle_pen_plotter_defines.svh.
`include "turtle_pen_plotter_defines.svh"

// A command word is taken at a rising edge where start is high and busy is
// low. Every result word appears on rsp for exactly one cycle with rsp_valid
// high, and the receiver cannot hold it off, so it must capture every word.
// Pen, turn, end, invalid, pen-up moves, refused moves and any command while
// halted are answered without a busy phase: the single result word shows up
// in the next cycle and busy never rises, so commands of this kind can arrive
// back to back. A pen-down move is a read-modify-write sweep of the grid
// memory through its single write port, a read state and a write state per
// row touched: a horizontal move touches one row, a vertical move of N cells
// touches N+1 rows, and its result word shows up in the first cycle with
// busy low again. A dump reads one row per cycle and streams GRID_SIZE
// result words, rows 0 upward, with last on the final one. The grid rows
// are cleared by reset through one valid bit per row, so no clearing pass
// is needed. After a refused move, an invalid code or end, every command
// returns a single halted word until reset.
module turtle_pen_plotter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tpp_pkg::cmd_t cmd,
    output logic          busy,
    output logic          rsp_valid,
    output tpp_pkg::rsp_t rsp
);

    localparam logic [6:0] GMAX7 = 7'(tpp_pkg::GRID_SIZE - 1);
    localparam logic [5:0] GMAX6 = 6'(tpp_pkg::GRID_SIZE - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DUMP
    } state_t;

    state_t                    state_reg, state_next;
    logic [5:0]                row_reg, row_next;
    logic [5:0]                col_reg, col_next;
    tpp_pkg::heading_t         facing_reg, facing_next;
    logic                      pen_reg, pen_next;
    logic                      halted_reg, halted_next;

    // Move walk: current row, rows still to go, end cell and column span.
    logic [5:0]                cur_reg, cur_next;
    logic [5:0]                rem_reg, rem_next;
    logic [5:0]                end_row_reg, end_row_next;
    logic [5:0]                end_col_reg, end_col_next;
    logic [5:0]                lo_reg, lo_next;
    logic [5:0]                hi_reg, hi_next;

    // Dump streaming: read counter and the row whose data is in flight.
    logic [tpp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      pend_reg, pend_next;
    logic [5:0]                pidx_reg, pidx_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    tpp_pkg::rsp_t             rsp_reg, rsp_next;

    // Grid memory: one row per word, single write port, registered read.
    logic [tpp_pkg::GRID_SIZE-1:0] grid_mem [tpp_pkg::GRID_SIZE];
    logic [tpp_pkg::GRID_SIZE-1:0] row_valid_reg;
    logic [tpp_pkg::GRID_SIZE-1:0] rdata_reg;
    logic                          rvld_reg;
    logic [tpp_pkg::AW-1:0]        raddr;
    logic                          mem_we;
    logic [tpp_pkg::GRID_SIZE-1:0] wdata;
    logic [tpp_pkg::GRID_SIZE-1:0] span_mask;

    // Shared step unit: one 7-bit add or subtract with its bound check.
    // It checks the move target on acceptance and steps the row walk.
    logic                      alu_sub;
    logic [5:0]                alu_a;
    logic [5:0]                alu_b;
    logic [6:0]                alu_sum;
    logic                      alu_oob;

    logic                      accept;
    logic                      vertical;

    assign accept   = start && (state_reg == S_IDLE);
    assign vertical = facing_reg[0];
    assign alu_sub  = facing_reg[1];
    assign alu_a    = (state_reg == S_IDLE) ? (vertical ? row_reg : col_reg) : cur_reg;
    assign alu_b    = (state_reg == S_IDLE) ? cmd.distance : 6'd1;
    assign alu_sum  = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_oob  = alu_sub ? alu_sum[6] : (alu_sum > GMAX7);

    assign span_mask = ({tpp_pkg::GRID_SIZE{1'b1}} << lo_reg)
                     & ({tpp_pkg::GRID_SIZE{1'b1}} >> (GMAX6 - hi_reg));
    assign wdata     = (rvld_reg ? rdata_reg : '0) | span_mask;
    assign mem_we    = (state_reg == S_MOVE_WR);
    assign raddr     = (state_reg == S_DUMP) ? cnt_reg[tpp_pkg::AW-1:0]
                                             : cur_reg[tpp_pkg::AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        facing_next    = facing_reg;
        pen_next       = pen_reg;
        halted_next    = halted_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        end_row_next   = end_row_reg;
        end_col_next   = end_col_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status = tpp_pkg::ST_OK;
                    if (halted_reg)
                    begin
                        rsp_next.status = tpp_pkg::ST_HALTED;
                        rsp_valid_next  = 1'b1;
                    end
                    else
                    begin
                        case (cmd.req_type)
                            tpp_pkg::REQ_PEN_UP:   pen_next = 1'b0;
                            tpp_pkg::REQ_PEN_DOWN: pen_next = 1'b1;
                            tpp_pkg::REQ_TURN_R:
                                facing_next = tpp_pkg::heading_t'(facing_reg + 2'd1);
                            tpp_pkg::REQ_TURN_L:
                                facing_next = tpp_pkg::heading_t'(facing_reg - 2'd1);
                            tpp_pkg::REQ_MOVE:
                            begin
                                if (alu_oob)
                                begin
                                    rsp_next.status = tpp_pkg::ST_OOB;
                                    halted_next     = 1'b1;
                                end
                                else if (!pen_reg)
                                begin
                                    if (vertical)
                                        row_next = alu_sum[5:0];
                                    else
                                        col_next = alu_sum[5:0];
                                end
                                else
                                begin
                                    cur_next     = row_reg;
                                    end_row_next = vertical ? alu_sum[5:0] : row_reg;
                                    end_col_next = vertical ? col_reg : alu_sum[5:0];
                                    rem_next     = vertical ? cmd.distance : 6'd0;
                                    if (vertical)
                                    begin
                                        lo_next = col_reg;
                                        hi_next = col_reg;
                                    end
                                    else
                                    begin
                                        lo_next = alu_sub ? alu_sum[5:0] : col_reg;
                                        hi_next = alu_sub ? col_reg : alu_sum[5:0];
                                    end
                                    state_next = S_MOVE_RD;
                                end
                            end
                            tpp_pkg::REQ_DUMP:
                            begin
                                cnt_next   = '0;
                                state_next = S_DUMP;
                            end
                            tpp_pkg::REQ_END: halted_next = 1'b1;
                            default:
                            begin
                                rsp_next.status = tpp_pkg::ST_INVALID;
                                halted_next     = 1'b1;
                            end
                        endcase
                        rsp_valid_next = (state_next == S_IDLE);
                    end
                    rsp_next.row_index = '0;
                    rsp_next.row_bits  = '0;
                    rsp_next.last      = 1'b1;
                    rsp_next.pos_row   = row_next;
                    rsp_next.pos_col   = col_next;
                    rsp_next.heading   = facing_next;
                    rsp_next.pen_down  = pen_next;
                end
            end
            S_MOVE_RD:
            begin
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                if (rem_reg == 6'd0)
                begin
                    row_next           = end_row_reg;
                    col_next           = end_col_reg;
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = tpp_pkg::ST_OK;
                    rsp_next.row_index = '0;
                    rsp_next.row_bits  = '0;
                    rsp_next.last      = 1'b1;
                    rsp_next.pos_row   = end_row_reg;
                    rsp_next.pos_col   = end_col_reg;
                    rsp_next.heading   = facing_reg;
                    rsp_next.pen_down  = pen_reg;
                    state_next         = S_IDLE;
                end
                else
                begin
                    cur_next   = alu_sum[5:0];
                    rem_next   = rem_reg - 6'd1;
                    state_next = S_MOVE_RD;
                end
            end
            S_DUMP:
            begin
                if (cnt_reg < tpp_pkg::CNT_W'(tpp_pkg::GRID_SIZE))
                begin
                    pend_next = 1'b1;
                    pidx_next = 6'(cnt_reg);
                    cnt_next  = cnt_reg + tpp_pkg::CNT_W'(1);
                end
                if (pend_reg)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = tpp_pkg::ST_OK;
                    rsp_next.row_index = pidx_reg;
                    rsp_next.row_bits  = rvld_reg ? 64'(rdata_reg) : 64'd0;
                    rsp_next.last      = (pidx_reg == GMAX6);
                    rsp_next.pos_row   = row_reg;
                    rsp_next.pos_col   = col_reg;
                    rsp_next.heading   = facing_reg;
                    rsp_next.pen_down  = pen_reg;
                    if (pidx_reg == GMAX6)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            facing_reg    <= tpp_pkg::HEAD_RIGHT;
            pen_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            cur_reg       <= '0;
            rem_reg       <= '0;
            end_row_reg   <= '0;
            end_col_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pidx_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            facing_reg    <= facing_next;
            pen_reg       <= pen_next;
            halted_reg    <= halted_next;
            cur_reg       <= cur_next;
            rem_reg       <= rem_next;
            end_row_reg   <= end_row_next;
            end_col_reg   <= end_col_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            pidx_reg      <= pidx_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            if (mem_we)
                row_valid_reg[cur_reg[tpp_pkg::AW-1:0]] <= 1'b1;
        end
    end

    // A row that was never written reads as cleared through its valid bit.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[cur_reg[tpp_pkg::AW-1:0]] <= wdata;
        rdata_reg <= grid_mem[raddr];
        rvld_reg  <= row_valid_reg[raddr];
    end

    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Error and halted words always close their command.
    `TPP_ASSERT_IMPLY(a_err_is_last, clk, rst_n, rsp_valid && (rsp.status != tpp_pkg::ST_OK), rsp.last)
    // Every accepted command either answers at once or keeps the block busy.
    `TPP_ASSERT_NEXT(a_accept_acts, clk, rst_n, start && !busy, rsp_valid || busy)
    // Only reset leaves the halted condition.
    `TPP_ASSERT_NEXT(a_halt_sticks, clk, rst_n, halted_reg, halted_reg)
    // The memory is written only from the move sweep, never while halted.
    `TPP_ASSERT_IMPLY(a_no_draw_halted, clk, rst_n, mem_we, !halted_reg)

endmodule
